@@ rtl/ccd_pkg.sv @@
package ccd_pkg;

    localparam int FIELD_BITS    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int NORM_BITS     = 8;
    localparam int DIST_BITS     = 18;
    localparam int THR_BITS      = 8;
    localparam int NUM_CHAN      = 3;
    localparam int CHAN_IDX_BITS = 2;
    localparam int STEP_BITS     = $clog2(NORM_BITS);
    localparam int SQ_BITS       = 2 * NORM_BITS;

    localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
    localparam int OUT_DATA_RAW  = DIST_BITS + 3 * NORM_BITS;
    localparam int OUT_DATA_BITS = ((OUT_DATA_RAW + 7) / 8) * 8;

    typedef logic [NORM_BITS-1:0]   norm_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DIST_BITS-1:0]   dist_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic start;
    } sq_ctrl_t;

endpackage

@@ rtl/ccd_div.sv @@
module ccd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ccd_pkg::sample_t  chan,
    input  ccd_pkg::sample_t  clear,
    output logic              done,
    output ccd_pkg::norm_t    quo
);

    localparam int SB  = ccd_pkg::SAMPLE_BITS;
    localparam int NB  = ccd_pkg::NORM_BITS;
    localparam int N_W = SB + NB + 2;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ccd_pkg::STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic                           sat_reg, sat_next;
    logic [SB:0]                    rem_reg, rem_next;
    logic [SB:0]                    div_reg, div_next;
    logic [NB-1:0]                  low_reg, low_next;
    ccd_pkg::norm_t                 q_reg, q_next;

    logic [N_W-1:0]  numer;
    logic [N_W-1:0]  sat_bound;
    logic            sat_in;
    logic [SB:0]     rem_init;
    logic [SB+1:0]   trial;
    logic [SB+1:0]   trial_sub;
    logic            fits;

    // The rounded quotient (512*chan + clear) / (2*clear) reaches 256 exactly when
    // 512*chan + clear >= 512*clear; a zero clear count lands here as well.
    always_comb
    begin
        numer     = N_W'({chan, 9'b0}) + N_W'(clear);
        sat_bound = N_W'({clear, 9'b0});
        sat_in    = numer >= sat_bound;
        rem_init  = (SB+1)'({chan, 1'b0}) + (SB+1)'(clear >> NB);
        trial     = {rem_reg, low_reg[NB-1]};
        fits      = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sat_next  = sat_in;
            rem_next  = rem_init;
            div_next  = {clear, 1'b0};
            low_next  = clear[NB-1:0];
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[SB:0] : trial[SB:0];
            q_next   = {q_reg[NB-2:0], fits};
            low_next = {low_reg[NB-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ccd_pkg::STEP_BITS'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = sat_reg ? '1 : q_reg;

endmodule

@@ rtl/ccd_sqacc.sv @@
module ccd_sqacc (
    input  logic                clk,
    input  logic                rst_n,
    input  ccd_pkg::sq_ctrl_t   ctrl,
    input  ccd_pkg::norm_t      a,
    input  ccd_pkg::norm_t      b,
    output logic                busy,
    output ccd_pkg::dist_t      acc
);

    localparam int NB = ccd_pkg::NORM_BITS;

    logic                               busy_reg, busy_next;
    logic [ccd_pkg::STEP_BITS-1:0]      cnt_reg, cnt_next;
    logic [ccd_pkg::SQ_BITS-1:0]        mcand_reg, mcand_next;
    ccd_pkg::norm_t                     mplier_reg, mplier_next;
    ccd_pkg::dist_t                     acc_reg, acc_next;
    ccd_pkg::norm_t                     diff;

    // Shift-and-add square of |a - b|, one multiplier bit per cycle, summed
    // straight into the running distance.
    always_comb
    begin
        diff        = (a >= b) ? a - b : b - a;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        if (ctrl.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = ccd_pkg::SQ_BITS'(diff);
            mplier_next = diff;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + ccd_pkg::DIST_BITS'(mcand_reg);
            end
            mcand_next  = {mcand_reg[ccd_pkg::SQ_BITS-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[NB-1:1]};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == ccd_pkg::STEP_BITS'(NB - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

@@ rtl/color_change_detector_core.sv @@
// Color change detector for one raw red, green, blue and clear sensor sample.
// The input stream (s_axis) carries one request per sample. Each color channel
// is normalized to round(256*channel/clear), saturated at 255, and the squared
// distance to the previous normalized triple is computed. The output stream
// (m_axis) carries the distance and the new triple in tdata and the change
// flag in tuser; the flag is set when the distance exceeds change_threshold.
// The threshold is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// After a request is accepted, the block passes through a start state, works
// the three channels in turn through a shared bit-serial divider, lets the
// bit-serial squarer finish the last channel and then posts the result.
// A new request is taken in the cycle after posting, so the block works on
// one sample at a time.
// A finished result sits in an output register, so the next request is taken
// and worked on while the receiver stalls; that request then waits for the
// output register to empty before its result is posted.
// Reset clears the threshold and the stored previous triple to zero, so the
// first sample is compared against black.
module color_change_detector_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ccd_pkg::THR_BITS-1:0]       cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_red, raw_green, raw_blue, raw_clear
    input  logic [ccd_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // distance_sq, norm_red, norm_green, norm_blue
    output logic [ccd_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // changed
    output logic                               m_axis_tuser
);

    localparam int FB = ccd_pkg::FIELD_BITS;
    localparam int SB = ccd_pkg::SAMPLE_BITS;

    ccd_pkg::state_t  state_reg, state_next;

    logic [ccd_pkg::CHAN_IDX_BITS-1:0]  ch_reg, ch_next;
    logic [ccd_pkg::THR_BITS-1:0]       thr_reg, thr_next;
    ccd_pkg::norm_t                     prev_reg [ccd_pkg::NUM_CHAN];
    ccd_pkg::norm_t                     norm_reg [ccd_pkg::NUM_CHAN];
    ccd_pkg::sample_t                   samp_reg [ccd_pkg::NUM_CHAN];
    ccd_pkg::sample_t                   clear_reg;

    logic                               out_valid_reg, out_valid_next;
    logic                               out_changed_reg;
    ccd_pkg::dist_t                     out_dist_reg;
    ccd_pkg::norm_t                     out_norm_reg [ccd_pkg::NUM_CHAN];

    logic                               in_take;
    logic                               out_free;
    logic                               post;
    logic                               div_start;
    logic                               div_done;
    ccd_pkg::norm_t                     div_quo;
    logic [ccd_pkg::CHAN_IDX_BITS-1:0]  div_idx;
    ccd_pkg::sample_t                   div_chan;
    ccd_pkg::sq_ctrl_t                  sq_ctrl;
    logic                               sq_busy;
    ccd_pkg::dist_t                     sq_acc;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ccd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ccd_pkg::ST_START;
                end
            end
            ccd_pkg::ST_START:
            begin
                state_next = ccd_pkg::ST_RUN;
                ch_next    = '0;
            end
            ccd_pkg::ST_RUN:
            begin
                if (div_done)
                begin
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == ccd_pkg::CHAN_IDX_BITS'(ccd_pkg::NUM_CHAN - 1))
                    begin
                        state_next = ccd_pkg::ST_FINISH;
                    end
                end
            end
            ccd_pkg::ST_FINISH:
            begin
                if (!sq_busy && !sq_ctrl.start && out_free)
                begin
                    state_next = ccd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ccd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        div_idx       = '0;
        sq_ctrl       = '0;
        post          = 1'b0;
        case (state_reg)
            ccd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ccd_pkg::ST_START:
            begin
                div_start     = 1'b1;
                sq_ctrl.clear = 1'b1;
            end
            ccd_pkg::ST_RUN:
            begin
                div_idx       = ch_reg + 1'b1;
                sq_ctrl.start = div_done;
                div_start     = div_done &&
                    (ch_reg != ccd_pkg::CHAN_IDX_BITS'(ccd_pkg::NUM_CHAN - 1));
            end
            ccd_pkg::ST_FINISH:
            begin
                post = !sq_busy && out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (div_idx)
            2'd1:    div_chan = samp_reg[1];
            2'd2:    div_chan = samp_reg[2];
            default: div_chan = samp_reg[0];
        endcase
    end

    ccd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .chan  (div_chan),
        .clear (clear_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    ccd_sqacc u_sqacc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sq_ctrl),
        .a     (div_quo),
        .b     (prev_reg[ch_reg]),
        .busy  (sq_busy),
        .acc   (sq_acc)
    );

    always_comb
    begin
        thr_next = cfg_we ? cfg_wdata : thr_reg;
        if (post)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccd_pkg::ST_IDLE;
            ch_reg        <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ccd_pkg::NUM_CHAN; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            if (post)
            begin
                for (int i = 0; i < ccd_pkg::NUM_CHAN; i++)
                begin
                    prev_reg[i] <= norm_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < ccd_pkg::NUM_CHAN; i++)
            begin
                samp_reg[i] <= s_axis_tdata[i*FB +: SB];
            end
            clear_reg <= s_axis_tdata[3*FB +: SB];
        end
        if (state_reg == ccd_pkg::ST_RUN && div_done)
        begin
            norm_reg[ch_reg] <= div_quo;
        end
        if (post)
        begin
            out_changed_reg <= sq_acc > ccd_pkg::DIST_BITS'(thr_reg);
            out_dist_reg    <= sq_acc;
            for (int i = 0; i < ccd_pkg::NUM_CHAN; i++)
            begin
                out_norm_reg[i] <= norm_reg[i];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_changed_reg;
    assign m_axis_tdata  = ccd_pkg::OUT_DATA_BITS'({out_norm_reg[2], out_norm_reg[1],
                                                    out_norm_reg[0], out_dist_reg});

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> !sq_busy)
        else $error("Squarer still busy when the next channel quotient arrived.");

    assert property (@(posedge clk) disable iff (!rst_n)
        post |=> m_axis_tvalid)
        else $error("Posted result did not show up on the output stream.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_axis_tready)
        else $error("A second request was taken while one was in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ccd_pkg::ST_FINISH && !sq_busy && out_free) |-> post)
        else $error("Finished result was held back from a free output register.");

endmodule

@@ tb/sv/color_change_detector_core_test.sv @@
module color_change_detector_core_test;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] clear;
    } raw_sample_t;

    typedef struct packed {
        logic           changed;
        ccd_pkg::dist_t distance;
        ccd_pkg::norm_t red;
        ccd_pkg::norm_t green;
        ccd_pkg::norm_t blue;
    } detection_t;

    typedef struct packed {
        raw_sample_t sample;
        logic        known;
        detection_t  want;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 19;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 250;

    // Rows with known set carry a result that follows directly from the
    // normalization rule; the others are checked against the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{1'b1, 18'd195075, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{1'b0, 18'd0, 8'd255, 8'd255, 8'd255}},
        '{'{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{1'b1, 18'd65025, 8'd255, 8'd0, 8'd255}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{1'b1, 18'd65025, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 16'd0, 16'd0, 16'hFFFF}, 1'b1, '{1'b1, 18'd195075, 8'd0, 8'd0, 8'd0}},
        '{'{16'd0, 16'd0, 16'd0, 16'd1}, 1'b1, '{1'b0, 18'd0, 8'd0, 8'd0, 8'd0}},
        '{'{16'd1, 16'd1, 16'd1, 16'd2}, 1'b0, '0},
        '{'{16'd1, 16'd3, 16'd5, 16'd512}, 1'b0, '0},
        '{'{16'd1000, 16'd2000, 16'hFFFF, 16'd10}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h0001, 16'h8000}, 1'b0, '0},
        '{'{16'h8000, 16'h7FFF, 16'h4000, 16'h8000}, 1'b0, '0},
        '{'{16'd127, 16'd255, 16'd128, 16'd256}, 1'b0, '0},
        '{'{16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0}, 1'b0, '0},
        '{'{16'd300, 16'd200, 16'd100, 16'd0}, 1'b0, '0},
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{1'b0, 18'd0, 8'd255, 8'd255, 8'd255}},
        '{'{16'd0, 16'd0, 16'd0, 16'd512}, 1'b1, '{1'b1, 18'd195075, 8'd0, 8'd0, 8'd0}},
        '{'{16'd1, 16'd0, 16'd0, 16'd512}, 1'b1, '{1'b1, 18'd1, 8'd1, 8'd0, 8'd0}},
        '{'{16'd1, 16'd0, 16'd0, 16'd512}, 1'b1, '{1'b0, 18'd0, 8'd1, 8'd0, 8'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ccd_pkg::THR_BITS-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [ccd_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [ccd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tuser;

    detection_t pending_detections [$];
    ccd_pkg::norm_t prev_norm_red = '0;
    ccd_pkg::norm_t prev_norm_green = '0;
    ccd_pkg::norm_t prev_norm_blue = '0;
    logic [7:0] threshold_setting = '0;
    raw_sample_t last_raw = '0;
    bit quiet = 1'b0;
    int ready_wait = 0;
    int error_count = 0;
    int request_count = 0;
    int result_count = 0;
    int setting_count = 1;

    color_change_detector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic ccd_pkg::norm_t chroma_of(logic [15:0] chan, logic [15:0] clear);
        int unsigned c;
        int unsigned k;
        int unsigned q;
        c = chan;
        k = clear;
        if (k == 0)
        begin
            return 8'd255;
        end
        q = (512 * c + k) / (2 * k);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic int unsigned square_gap(ccd_pkg::norm_t a, ccd_pkg::norm_t b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    function automatic detection_t predict_detection(raw_sample_t s);
        detection_t d;
        int unsigned dist_total;
        d.red = chroma_of(s.red, s.clear);
        d.green = chroma_of(s.green, s.clear);
        d.blue = chroma_of(s.blue, s.clear);
        dist_total = square_gap(d.red, prev_norm_red) + square_gap(d.green, prev_norm_green)
            + square_gap(d.blue, prev_norm_blue);
        d.distance = dist_total[17:0];
        d.changed = dist_total > threshold_setting;
        prev_norm_red = d.red;
        prev_norm_green = d.green;
        prev_norm_blue = d.blue;
        return d;
    endfunction

    function automatic logic [15:0] channel_near(ccd_pkg::norm_t prev, logic [15:0] clear);
        int target;
        int unsigned raw;
        target = int'(prev) + $urandom_range(0, 12) - 6;
        if (target < 0)
        begin
            target = 0;
        end
        if (target > 255)
        begin
            target = 255;
        end
        raw = (target * clear) >> 8;
        return raw[15:0];
    endfunction

    // 45% of the samples drift a little from the last normalized color, so
    // the distance lands close to the threshold; the rest cover the corners.
    function automatic raw_sample_t random_sample();
        raw_sample_t s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        s.red = $urandom_range(0, 16'hFFFF);
        s.green = $urandom_range(0, 16'hFFFF);
        s.blue = $urandom_range(0, 16'hFFFF);
        s.clear = $urandom_range(0, 16'hFFFF);
        if (pick < 45)
        begin
            s.clear = $urandom_range(256, 16'hFFFF);
            s.red = channel_near(prev_norm_red, s.clear);
            s.green = channel_near(prev_norm_green, s.clear);
            s.blue = channel_near(prev_norm_blue, s.clear);
        end
        else if (pick < 75)
        begin
            s.clear = '0;
        end
        else if (pick < 83)
        begin
            s.clear = $urandom_range(1, 255);
        end
        else if (pick < 91)
        begin
            s = last_raw;
        end
        else if (pick < 100)
        begin
            s.clear = $urandom_range(1, 16);
            s.red = $urandom_range(0, 2 * s.clear);
            s.green = $urandom_range(0, 2 * s.clear);
            s.blue = $urandom_range(0, 2 * s.clear);
        end
        if (pick >= 65 && pick < 75)
        begin
            s.clear = '0;
        end
        else if (pick >= 45 && pick < 65)
        begin
            s.clear = $urandom_range(0, 16'hFFFF);
        end
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic send_request(raw_sample_t s, logic known, detection_t want);
        int gap;
        detection_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.clear, s.blue, s.green, s.red};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = predict_detection(s);
        pending_detections.push_back(known ? want : predicted);
        last_raw = s;
        request_count++;
    endtask

    task automatic write_threshold(logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_detections.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_setting = value;
        setting_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        detection_t got;
        detection_t want;
        int next_wait;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_wait <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.changed = m_axis_tuser;
                got.distance = m_axis_tdata[17:0];
                got.red = m_axis_tdata[25:18];
                got.green = m_axis_tdata[33:26];
                got.blue = m_axis_tdata[41:34];
                result_count++;
                if (pending_detections.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = pending_detections.pop_front();
                    if (got.changed !== want.changed)
                    begin
                        report_mismatch($sformatf("changed got %0d want %0d",
                            got.changed, want.changed));
                    end
                    if (got.distance !== want.distance)
                    begin
                        report_mismatch($sformatf("distance_sq got %0d want %0d",
                            got.distance, want.distance));
                    end
                    if (got.red !== want.red)
                    begin
                        report_mismatch($sformatf("norm_red got %0d want %0d",
                            got.red, want.red));
                    end
                    if (got.green !== want.green)
                    begin
                        report_mismatch($sformatf("norm_green got %0d want %0d",
                            got.green, want.green));
                    end
                    if (got.blue !== want.blue)
                    begin
                        report_mismatch($sformatf("norm_blue got %0d want %0d",
                            got.blue, want.blue));
                    end
                end
                next_wait = quiet ? 0 : $urandom_range(0, 10);
                ready_wait <= next_wait;
                m_axis_tready <= (next_wait == 0);
            end
            else if (ready_wait > 0)
            begin
                ready_wait <= ready_wait - 1;
                m_axis_tready <= (ready_wait == 1);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] phase_thresholds [PHASE_COUNT];
        phase_thresholds = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd254, 8'd0, 8'd0};
        phase_thresholds[4] = $urandom_range(0, 255);
        phase_thresholds[6] = $urandom_range(2, 64);
        phase_thresholds[7] = $urandom_range(0, 255);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_request(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].known,
                DIRECTED_ROWS[i].want);
        end
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_threshold(phase_thresholds[p]);
            quiet = (p == 3) || (p == 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_request(random_sample(), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_detections.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d samples and checked %0d results under %0d threshold settings,",
            request_count, result_count, setting_count);
        $display("including zero clear counts, saturation and distances near the threshold.");
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ccd_pkg.sv
rtl/ccd_div.sv
rtl/ccd_sqacc.sv
rtl/color_change_detector_core.sv
tb/sv/color_change_detector_core_test.sv
